// ----- rtl/lle_pkg.sv -----
package lle_pkg;

    // Line buffer and CSI parameter limits
    localparam int LINE_MAX    = 64;
    localparam int PARAM_SLOTS = 16;
    localparam int ADDR_W      = $clog2(LINE_MAX);
    localparam int LEN_W       = 7;
    localparam int PC_W        = $clog2(PARAM_SLOTS);

    // Command queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Key codes
    localparam logic [7:0] KEY_ESC   = 8'h1b;
    localparam logic [7:0] KEY_DEL   = 8'h7f;
    localparam logic [7:0] KEY_HOME  = 8'h01;
    localparam logic [7:0] KEY_END   = 8'h05;
    localparam logic [7:0] KEY_KILL  = 8'h15;
    localparam logic [7:0] KEY_LF    = 8'h0a;
    localparam logic [7:0] KEY_CR    = 8'h0d;
    localparam logic [7:0] KEY_SPACE = 8'h20;
    localparam logic [7:0] KEY_TILDE = 8'h7e;
    localparam logic [7:0] KEY_LBRK  = 8'h5b;
    localparam logic [7:0] KEY_QUEST = 8'h3f;
    localparam logic [7:0] KEY_SEMI  = 8'h3b;
    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;
    localparam logic [7:0] KEY_UP    = 8'h41;
    localparam logic [7:0] KEY_DOWN  = 8'h42;
    localparam logic [7:0] KEY_RIGHT = 8'h43;
    localparam logic [7:0] KEY_LEFT  = 8'h44;

    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_INSERT   = 4'd1,
        OP_DEL_BACK = 4'd2,
        OP_DEL_FWD  = 4'd3,
        OP_HOME     = 4'd4,
        OP_END      = 4'd5,
        OP_CLEAR    = 4'd6,
        OP_LEFT     = 4'd7,
        OP_RIGHT    = 4'd8,
        OP_LINE_END = 4'd9
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] key;
    } t_cmd;

    typedef enum logic [3:0] {
        PH_TEXT  = 4'b0001,
        PH_ESC   = 4'b0010,
        PH_CSI   = 4'b0100,
        PH_PARAM = 4'b1000
    } t_phase;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_INS_RD  = 8'b0000_0010,
        ST_INS_WR  = 8'b0000_0100,
        ST_DEL_RD  = 8'b0000_1000,
        ST_DEL_WR  = 8'b0001_0000,
        ST_RD_ADDR = 8'b0010_0000,
        ST_RD_EMIT = 8'b0100_0000,
        ST_STATUS  = 8'b1000_0000
    } t_bstate;

endpackage

// ----- rtl/lle_front.sv -----
module lle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_key_byte,
    output logic          o_push,
    output lle_pkg::t_cmd o_cmd,
    input  logic          i_full
);

    lle_pkg::t_phase               r_phase, n_phase;
    logic [lle_pkg::PC_W-1:0]      r_pc, n_pc;
    logic [lle_pkg::PC_W-1:0]      pc_eff;
    logic                          accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // Classify the byte and advance the escape parser
    always_comb begin
        n_phase   = r_phase;
        n_pc      = r_pc;
        pc_eff    = r_pc;
        o_cmd.op  = lle_pkg::OP_NOP;
        o_cmd.key = i_key_byte;
        if (i_key_byte == lle_pkg::KEY_LF || i_key_byte == lle_pkg::KEY_CR) begin
            o_cmd.op = lle_pkg::OP_LINE_END;
            n_phase  = lle_pkg::PH_TEXT;
        end else begin
            case (r_phase)
                lle_pkg::PH_TEXT: begin
                    if (i_key_byte == lle_pkg::KEY_ESC) begin
                        n_phase = lle_pkg::PH_ESC;
                    end else if (i_key_byte == lle_pkg::KEY_DEL) begin
                        o_cmd.op = lle_pkg::OP_DEL_BACK;
                    end else if (i_key_byte >= lle_pkg::KEY_SPACE &&
                                 i_key_byte <= lle_pkg::KEY_TILDE) begin
                        o_cmd.op = lle_pkg::OP_INSERT;
                    end else if (i_key_byte == lle_pkg::KEY_HOME) begin
                        o_cmd.op = lle_pkg::OP_HOME;
                    end else if (i_key_byte == lle_pkg::KEY_END) begin
                        o_cmd.op = lle_pkg::OP_END;
                    end else if (i_key_byte == lle_pkg::KEY_KILL) begin
                        o_cmd.op = lle_pkg::OP_CLEAR;
                    end
                end
                lle_pkg::PH_ESC: begin
                    n_phase = (i_key_byte == lle_pkg::KEY_LBRK) ? lle_pkg::PH_CSI
                                                                 : lle_pkg::PH_TEXT;
                end
                lle_pkg::PH_CSI, lle_pkg::PH_PARAM: begin
                    if (r_phase == lle_pkg::PH_CSI) begin
                        pc_eff  = '0;
                        n_pc    = '0;
                        n_phase = lle_pkg::PH_PARAM;
                    end
                    if (r_phase == lle_pkg::PH_CSI && i_key_byte == lle_pkg::KEY_QUEST) begin
                        n_phase = lle_pkg::PH_PARAM;
                    end else if (i_key_byte == lle_pkg::KEY_SEMI &&
                                 pc_eff < lle_pkg::PC_W'(lle_pkg::PARAM_SLOTS - 1)) begin
                        n_pc = pc_eff + 1'b1;
                    end else if (i_key_byte >= lle_pkg::KEY_ZERO &&
                                 i_key_byte <= lle_pkg::KEY_NINE) begin
                        n_phase = lle_pkg::PH_PARAM;
                    end else begin
                        n_phase = lle_pkg::PH_TEXT;
                        if (i_key_byte == lle_pkg::KEY_UP ||
                            i_key_byte == lle_pkg::KEY_DOWN) begin
                            o_cmd.op = lle_pkg::OP_CLEAR;
                        end else if (i_key_byte == lle_pkg::KEY_LEFT) begin
                            o_cmd.op = lle_pkg::OP_LEFT;
                        end else if (i_key_byte == lle_pkg::KEY_RIGHT) begin
                            o_cmd.op = lle_pkg::OP_RIGHT;
                        end else if (i_key_byte == lle_pkg::KEY_TILDE) begin
                            o_cmd.op = lle_pkg::OP_DEL_FWD;
                        end
                    end
                end
                default: begin
                    n_phase = lle_pkg::PH_TEXT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lle_pkg::PH_TEXT;
            r_pc    <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pc    <= n_pc;
        end
    end

endmodule

// ----- rtl/lle_queue.sv -----
module lle_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lle_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lle_pkg::t_cmd o_cmd
);

    lle_pkg::t_cmd                 r_mem [lle_pkg::QUEUE_DEPTH];
    logic [lle_pkg::QPTR_W-1:0]    r_wptr, r_rptr;
    logic [lle_pkg::QCNT_W-1:0]    r_count;
    logic                          do_pop;

    assign o_full  = (r_count == lle_pkg::QCNT_W'(lle_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if ((i_push && !o_full) && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!(i_push && !o_full) && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/lle_back.sv -----
module lle_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  lle_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_line_byte,
    output logic [lle_pkg::LEN_W-1:0]  o_cursor_pos,
    output logic [lle_pkg::LEN_W-1:0]  o_line_length,
    output logic                       o_line_done,
    output logic                       o_line_empty,
    output logic                       o_last_of_run,
    output logic                       o_insert_dropped
);

    localparam int LEN_W = lle_pkg::LEN_W;
    localparam int ADDR_W = lle_pkg::ADDR_W;

    logic [7:0]          r_mem [lle_pkg::LINE_MAX];
    logic [7:0]          r_rd_data;

    lle_pkg::t_bstate    r_state, n_state;
    logic [LEN_W-1:0]    r_cursor, n_cursor;
    logic [LEN_W-1:0]    r_held, n_held;
    logic [LEN_W-1:0]    r_ptr, n_ptr;
    lle_pkg::t_op        r_op, n_op;
    logic [7:0]          r_key, n_key;
    logic                r_drop, n_drop;

    logic                wr_en, rd_en;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic [7:0]          wr_data;

    logic                r_out_valid;
    logic [7:0]          r_out_byte, n_out_byte;
    logic [LEN_W-1:0]    r_out_cursor, n_out_cursor;
    logic [LEN_W-1:0]    r_out_len, n_out_len;
    logic                r_out_done, n_out_done;
    logic                r_out_empty, n_out_empty;
    logic                r_out_last, n_out_last;
    logic                r_out_drop, n_out_drop;
    logic                load;
    logic                slot_free;
    logic                line_is_empty;
    logic                last_byte;

    assign slot_free     = !r_out_valid || i_ready;
    assign line_is_empty = (r_held == '0);
    assign last_byte     = line_is_empty || ((r_ptr + 1'b1) == r_held);

    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_held       = r_held;
        n_ptr        = r_ptr;
        n_op         = r_op;
        n_key        = r_key;
        n_drop       = r_drop;
        o_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_ptr[ADDR_W-1:0];
        wr_data      = r_rd_data;
        rd_en        = 1'b0;
        rd_addr      = r_ptr[ADDR_W-1:0];
        load         = 1'b0;
        n_out_byte   = 8'h00;
        n_out_cursor = r_cursor;
        n_out_len    = r_held;
        n_out_done   = 1'b0;
        n_out_empty  = 1'b0;
        n_out_last   = 1'b1;
        n_out_drop   = r_drop;
        case (r_state)
            lle_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_op    = i_cmd.op;
                    n_key   = i_cmd.key;
                    n_drop  = 1'b0;
                    n_state = lle_pkg::ST_STATUS;
                    case (i_cmd.op)
                        lle_pkg::OP_HOME: n_cursor = '0;
                        lle_pkg::OP_END:  n_cursor = r_held;
                        lle_pkg::OP_CLEAR: begin
                            n_cursor = '0;
                            n_held   = '0;
                        end
                        lle_pkg::OP_LEFT: begin
                            if (r_cursor != '0) n_cursor = r_cursor - 1'b1;
                        end
                        lle_pkg::OP_RIGHT: begin
                            if (r_cursor < r_held) n_cursor = r_cursor + 1'b1;
                        end
                        lle_pkg::OP_INSERT: begin
                            if (r_held == LEN_W'(lle_pkg::LINE_MAX)) begin
                                n_drop = 1'b1;
                            end else begin
                                n_ptr   = r_held;
                                n_state = lle_pkg::ST_INS_RD;
                            end
                        end
                        lle_pkg::OP_DEL_BACK: begin
                            if (r_cursor != '0) begin
                                n_ptr   = r_cursor - 1'b1;
                                n_state = lle_pkg::ST_DEL_RD;
                            end
                        end
                        lle_pkg::OP_DEL_FWD: begin
                            if (r_cursor < r_held) begin
                                n_ptr   = r_cursor;
                                n_state = lle_pkg::ST_DEL_RD;
                            end
                        end
                        lle_pkg::OP_LINE_END: begin
                            n_ptr   = '0;
                            n_state = lle_pkg::ST_RD_ADDR;
                        end
                        default: begin
                            n_state = lle_pkg::ST_STATUS;
                        end
                    endcase
                end
            end
            lle_pkg::ST_INS_RD: begin
                // Open a gap at the cursor, moving one byte at a time from the tail (read, then write)
                if (r_ptr == r_cursor) begin
                    wr_en    = 1'b1;
                    wr_addr  = r_cursor[ADDR_W-1:0];
                    wr_data  = r_key;
                    n_cursor = r_cursor + 1'b1;
                    n_held   = r_held + 1'b1;
                    n_state  = lle_pkg::ST_STATUS;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(r_ptr - 1'b1);
                    n_state = lle_pkg::ST_INS_WR;
                end
            end
            lle_pkg::ST_INS_WR: begin
                wr_en   = 1'b1;
                n_ptr   = r_ptr - 1'b1;
                n_state = lle_pkg::ST_INS_RD;
            end
            lle_pkg::ST_DEL_RD: begin
                // Close the gap toward the head
                if ((r_ptr + 1'b1) >= r_held) begin
                    n_held = r_held - 1'b1;
                    if (r_op == lle_pkg::OP_DEL_BACK) n_cursor = r_cursor - 1'b1;
                    n_state = lle_pkg::ST_STATUS;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(r_ptr + 1'b1);
                    n_state = lle_pkg::ST_DEL_WR;
                end
            end
            lle_pkg::ST_DEL_WR: begin
                wr_en   = 1'b1;
                n_ptr   = r_ptr + 1'b1;
                n_state = lle_pkg::ST_DEL_RD;
            end
            lle_pkg::ST_RD_ADDR: begin
                rd_en   = 1'b1;
                n_state = lle_pkg::ST_RD_EMIT;
            end
            lle_pkg::ST_RD_EMIT: begin
                if (slot_free) begin
                    load         = 1'b1;
                    n_out_byte   = line_is_empty ? 8'h00 : r_rd_data;
                    n_out_cursor = '0;
                    n_out_len    = r_held;
                    n_out_done   = 1'b1;
                    n_out_empty  = line_is_empty;
                    n_out_last   = last_byte;
                    n_out_drop   = 1'b0;
                    if (last_byte) begin
                        n_cursor = '0;
                        n_held   = '0;
                        n_state  = lle_pkg::ST_IDLE;
                    end else begin
                        n_ptr   = r_ptr + 1'b1;
                        n_state = lle_pkg::ST_RD_ADDR;
                    end
                end
            end
            lle_pkg::ST_STATUS: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = lle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lle_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lle_pkg::ST_IDLE;
            r_cursor    <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_held      <= n_held;
            r_out_valid <= load || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_op   <= n_op;
        r_key  <= n_key;
        r_drop <= n_drop;
        if (load) begin
            r_out_byte   <= n_out_byte;
            r_out_cursor <= n_out_cursor;
            r_out_len    <= n_out_len;
            r_out_done   <= n_out_done;
            r_out_empty  <= n_out_empty;
            r_out_last   <= n_out_last;
            r_out_drop   <= n_out_drop;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_line_byte      = r_out_byte;
    assign o_cursor_pos     = r_out_cursor;
    assign o_line_length    = r_out_len;
    assign o_line_done      = r_out_done;
    assign o_line_empty     = r_out_empty;
    assign o_last_of_run    = r_out_last;
    assign o_insert_dropped = r_out_drop;

endmodule

// ----- rtl/ansi_line_editor.sv -----
// Channel   Direction  Handshake           Payload
// key in    input      i_valid / o_ready   i_key_byte
// result    output     o_valid / i_ready   o_line_byte, o_cursor_pos, o_line_length,
//                                          o_line_done, o_line_empty, o_last_of_run,
//                                          o_insert_dropped
//
// Front: one key transaction per cycle while the queue is not full, into a two-entry command queue.
// Back: a cursor or status-only key goes straight to its status result; insert,
// backspace and forward delete shift the tail one byte at a time (read, then write).
// Readout reads and emits the line one byte at a time. Synchronous active-low reset
// clears the control state only, not the line store, queue entries or data registers.
// A result stall holds the back; the front takes keys until the queue fills.
module ansi_line_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_key_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_line_byte,
    output logic [6:0] o_cursor_pos,
    output logic [6:0] o_line_length,
    output logic       o_line_done,
    output logic       o_line_empty,
    output logic       o_last_of_run,
    output logic       o_insert_dropped
);

    // Classified key commands between front and back
    lle_pkg::t_cmd push_cmd;
    lle_pkg::t_cmd pop_cmd;
    logic          push;
    logic          full;
    logic          pop;
    logic          cmd_valid;

    // Decode keys and track the escape sequence state
    lle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_key_byte (i_key_byte),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (full)
    );

    // Decouple decode from the buffer editor
    lle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (pop_cmd)
    );

    // Edit the line store and drive results
    lle_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_valid),
        .i_cmd            (pop_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_line_byte      (o_line_byte),
        .o_cursor_pos     (o_cursor_pos),
        .o_line_length    (o_line_length),
        .o_line_done      (o_line_done),
        .o_line_empty     (o_line_empty),
        .o_last_of_run    (o_last_of_run),
        .o_insert_dropped (o_insert_dropped)
    );

endmodule

// ----- rtl/lle_checker.sv -----
module lle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_line_byte,
    input logic [6:0] o_cursor_pos,
    input logic [6:0] o_line_length,
    input logic       o_line_done,
    input logic       o_line_empty,
    input logic       o_last_of_run,
    input logic       o_insert_dropped
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_line_byte) && $stable(o_last_of_run))
        else $error("result changed under stall");

    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_line_done |-> o_cursor_pos <= o_line_length && o_line_length <= 7'd64)
        else $error("cursor beyond line length");

    a_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_done |-> o_cursor_pos == 7'd0 && !o_insert_dropped)
        else $error("bad readout status");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_empty |->
            o_line_done && o_last_of_run && o_line_length == 7'd0 && o_line_byte == 8'd0)
        else $error("bad empty line result");

endmodule

bind ansi_line_editor lle_checker u_lle_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_line_byte      (o_line_byte),
    .o_cursor_pos     (o_cursor_pos),
    .o_line_length    (o_line_length),
    .o_line_done      (o_line_done),
    .o_line_empty     (o_line_empty),
    .o_last_of_run    (o_last_of_run),
    .o_insert_dropped (o_insert_dropped)
);

// ----- verif/ansi_line_editor_tb.sv -----
`timescale 1ns / 100ps

module ansi_line_editor_tb;

    // Total key transactions to send, directed rows included
    localparam int KEYS_TOTAL  = 350;
    // Cycles with no transaction on either side before the run is abandoned
    localparam int STALL_LIMIT = 4000;
    // Quiet cycles after the last expected result, to catch stray output
    localparam int TAIL_CYCLES = 40;
    localparam int N_DIR       = 27;

    // One result transaction, field by field
    typedef struct packed {
        logic [7:0] data;
        logic [6:0] cursor;
        logic [6:0] length;
        logic       done;
        logic       empty;
        logic       last;
        logic       dropped;
    } t_line_result;

    // A directed row: the key and, where obvious, its single result
    typedef struct {
        logic [7:0]   key;
        bit           typed;
        t_line_result want;
    } t_key_row;

    localparam t_line_result EMPTY_LINE = '{8'd0, 7'd0, 7'd0, 1'b1, 1'b1, 1'b1, 1'b0};

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic [7:0] i_key_byte = 8'd0;
    logic       i_ready    = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_line_byte;
    logic [6:0] o_cursor_pos;
    logic [6:0] o_line_length;
    logic       o_line_done;
    logic       o_line_empty;
    logic       o_last_of_run;
    logic       o_insert_dropped;

    // Editor image: line bytes, cursor, length, parser phase and separator count
    logic [7:0]               line_copy [lle_pkg::LINE_MAX];
    logic [6:0]               cursor_copy = 7'd0;
    logic [6:0]               length_copy = 7'd0;
    lle_pkg::t_phase          phase_copy  = lle_pkg::PH_TEXT;
    logic [lle_pkg::PC_W-1:0] semis_copy  = '0;

    t_line_result results_due [$];   // results still owed by the editor, oldest first
    t_line_result key_results [$];   // results caused by the key just taken
    t_key_row     dir_rows [N_DIR];

    int keys_sent  = 0;
    int fail_count = 0;
    bit calm       = 1'b0;   // set: no gaps on either side
    int ready_hold = 0;

    ansi_line_editor i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_line_result status_of(int cur, int len);
        return '{8'd0, 7'(cur), 7'(len), 1'b0, 1'b0, 1'b1, 1'b0};
    endfunction

    // Remove the byte left of the cursor, closing the gap
    function automatic void erase_before_cursor();
        int i;
        if (cursor_copy == 7'd0)
            return;
        for (i = int'(cursor_copy) - 1; i + 1 < int'(length_copy); i++)
            line_copy[i] = line_copy[i + 1];
        cursor_copy--;
        length_copy--;
    endfunction

    // Apply one key to the editor image and collect the results it causes
    function automatic void edit_line(input logic [7:0] k);
        logic         refused;
        int           i;
        int           n;
        t_line_result res;
        refused = 1'b0;
        key_results.delete();

        // Line end wins in every parser phase: read the line out, start fresh
        if (k == lle_pkg::KEY_CR || k == lle_pkg::KEY_LF) begin
            n = length_copy;
            if (n == 0)
                key_results.push_back(EMPTY_LINE);
            for (i = 0; i < n; i++)
                key_results.push_back('{line_copy[i], 7'd0, 7'(n), 1'b1, 1'b0,
                                        i == n - 1, 1'b0});
            cursor_copy = 7'd0;
            length_copy = 7'd0;
            phase_copy  = lle_pkg::PH_TEXT;
            return;
        end

        case (phase_copy)
            lle_pkg::PH_TEXT: begin
                if (k == lle_pkg::KEY_ESC) begin
                    phase_copy = lle_pkg::PH_ESC;
                end else if (k == lle_pkg::KEY_DEL) begin
                    erase_before_cursor();
                end else if (k >= lle_pkg::KEY_SPACE && k <= lle_pkg::KEY_TILDE) begin
                    if (length_copy == lle_pkg::LINE_MAX) begin
                        refused = 1'b1;
                    end else begin
                        for (i = length_copy; i > int'(cursor_copy); i--)
                            line_copy[i] = line_copy[i - 1];
                        line_copy[cursor_copy[5:0]] = k;
                        cursor_copy++;
                        length_copy++;
                    end
                end else if (k == lle_pkg::KEY_HOME) begin
                    cursor_copy = 7'd0;
                end else if (k == lle_pkg::KEY_END) begin
                    cursor_copy = length_copy;
                end else if (k == lle_pkg::KEY_KILL) begin
                    cursor_copy = 7'd0;
                    length_copy = 7'd0;
                end
            end
            lle_pkg::PH_ESC: begin
                phase_copy = (k == lle_pkg::KEY_LBRK) ? lle_pkg::PH_CSI : lle_pkg::PH_TEXT;
            end
            default: begin
                // A '?' right after the bracket is skipped
                if (phase_copy == lle_pkg::PH_CSI && k == lle_pkg::KEY_QUEST) begin
                    semis_copy = '0;
                    phase_copy = lle_pkg::PH_PARAM;
                end else begin
                    if (phase_copy == lle_pkg::PH_CSI)
                        semis_copy = '0;
                    phase_copy = lle_pkg::PH_PARAM;
                    if (k == lle_pkg::KEY_SEMI && semis_copy < lle_pkg::PARAM_SLOTS - 1) begin
                        semis_copy++;
                    end else if (k < lle_pkg::KEY_ZERO || k > lle_pkg::KEY_NINE) begin
                        // Terminator, including a separator past the last slot
                        phase_copy = lle_pkg::PH_TEXT;
                        case (k)
                            lle_pkg::KEY_UP, lle_pkg::KEY_DOWN: begin
                                cursor_copy = 7'd0;
                                length_copy = 7'd0;
                            end
                            lle_pkg::KEY_LEFT: begin
                                if (cursor_copy > 7'd0)
                                    cursor_copy--;
                            end
                            lle_pkg::KEY_RIGHT: begin
                                if (cursor_copy < length_copy)
                                    cursor_copy++;
                            end
                            lle_pkg::KEY_TILDE: begin
                                if (cursor_copy < length_copy) begin
                                    cursor_copy++;
                                    erase_before_cursor();
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
        endcase

        res = status_of(cursor_copy, length_copy);
        res.dropped = refused;
        key_results.push_back(res);
    endfunction

    // Gap length before a transaction: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one key, hold it until taken, then queue what it should cause
    task automatic send_key(input logic [7:0] k, input bit typed = 1'b0,
                            input t_line_result want = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_key_byte <= k;
        do @(posedge i_clk); while (!o_ready);
        edit_line(k);
        if (typed)
            results_due.push_back(want);
        else
            foreach (key_results[j])
                results_due.push_back(key_results[j]);
        keys_sent++;
    endtask

    task automatic check_result();
        t_line_result want;
        if (results_due.size() == 0) begin
            $error("unexpected result: line_byte %0h cursor_pos %0d line_length %0d",
                   o_line_byte, o_cursor_pos, o_line_length);
            fail_count++;
            return;
        end
        want = results_due.pop_front();
        if (o_line_byte !== want.data) begin
            $error("line_byte: expected %0h, got %0h", want.data, o_line_byte);
            fail_count++;
        end
        if (o_cursor_pos !== want.cursor) begin
            $error("cursor_pos: expected %0d, got %0d", want.cursor, o_cursor_pos);
            fail_count++;
        end
        if (o_line_length !== want.length) begin
            $error("line_length: expected %0d, got %0d", want.length, o_line_length);
            fail_count++;
        end
        if (o_line_done !== want.done) begin
            $error("line_done: expected %0b, got %0b", want.done, o_line_done);
            fail_count++;
        end
        if (o_line_empty !== want.empty) begin
            $error("line_empty: expected %0b, got %0b", want.empty, o_line_empty);
            fail_count++;
        end
        if (o_last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
            fail_count++;
        end
        if (o_insert_dropped !== want.dropped) begin
            $error("insert_dropped: expected %0b, got %0b", want.dropped, o_insert_dropped);
            fail_count++;
        end
    endtask

    // Result side: check each transaction, then shape ready in stretches.
    // Stall stretches are mostly short with the odd long one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_result();
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm || $urandom_range(0, 1)) begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end else begin
            i_ready    <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    // Watchdog: abandon the run when nothing moves on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int r;
        int n;

        // Directed rows walk every edit key but up (down stands for both), the CSI forms and the
        // line-end corner cases; results are typed in where obvious.
        dir_rows = '{
            '{lle_pkg::KEY_CR,    1'b1, EMPTY_LINE},        // empty line right after reset
            '{lle_pkg::KEY_DEL,   1'b1, status_of(0, 0)},   // backspace at home does nothing
            '{lle_pkg::KEY_SPACE, 1'b1, status_of(1, 1)},   // lowest printable
            '{lle_pkg::KEY_TILDE, 1'b1, status_of(2, 2)},   // highest printable
            '{lle_pkg::KEY_HOME,  1'b1, status_of(0, 2)},
            '{lle_pkg::KEY_END,   1'b1, status_of(2, 2)},
            '{lle_pkg::KEY_ESC,   1'b0, '0},
            '{lle_pkg::KEY_LBRK,  1'b0, '0},
            '{lle_pkg::KEY_LEFT,  1'b0, '0},
            '{lle_pkg::KEY_ESC,   1'b0, '0},                // private-mode form with a parameter
            '{lle_pkg::KEY_LBRK,  1'b0, '0},
            '{lle_pkg::KEY_QUEST, 1'b0, '0},
            '{lle_pkg::KEY_NINE,  1'b0, '0},
            '{lle_pkg::KEY_SEMI,  1'b0, '0},
            '{lle_pkg::KEY_TILDE, 1'b0, '0},                // forward delete
            '{lle_pkg::KEY_ESC,   1'b0, '0},
            '{lle_pkg::KEY_LBRK,  1'b0, '0},
            '{lle_pkg::KEY_RIGHT, 1'b0, '0},                // right at end of line
            '{lle_pkg::KEY_LF,    1'b0, '0},
            '{8'h61,              1'b1, status_of(1, 1)},
            '{lle_pkg::KEY_ESC,   1'b0, '0},
            '{lle_pkg::KEY_LBRK,  1'b0, '0},
            '{lle_pkg::KEY_DOWN,  1'b0, '0},                // history recall clears the line
            '{lle_pkg::KEY_KILL,  1'b1, status_of(0, 0)},
            '{lle_pkg::KEY_ESC,   1'b0, '0},                // line end inside an escape
            '{lle_pkg::KEY_LBRK,  1'b0, '0},
            '{lle_pkg::KEY_CR,    1'b1, EMPTY_LINE}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[d])
            send_key(dir_rows[d].key, dir_rows[d].typed, dir_rows[d].want);

        // Overfill the line, try an insert at home on the full line,
        // then make room at the front and refill it: longest shift and readout
        repeat (lle_pkg::LINE_MAX + 2)
            send_key(8'($urandom_range(lle_pkg::KEY_SPACE, lle_pkg::KEY_TILDE)));
        send_key(lle_pkg::KEY_HOME);
        send_key(8'($urandom_range(lle_pkg::KEY_SPACE, lle_pkg::KEY_TILDE)));
        send_key(lle_pkg::KEY_ESC);
        send_key(lle_pkg::KEY_LBRK);
        send_key(lle_pkg::KEY_RIGHT);
        send_key(lle_pkg::KEY_DEL);
        send_key(8'($urandom_range(lle_pkg::KEY_SPACE, lle_pkg::KEY_TILDE)));
        send_key(lle_pkg::KEY_CR);

        // Separator overflow: the sixteenth ';' ends the sequence
        send_key(lle_pkg::KEY_ESC);
        send_key(lle_pkg::KEY_LBRK);
        repeat (lle_pkg::PARAM_SLOTS)
            send_key(lle_pkg::KEY_SEMI);
        send_key(lle_pkg::KEY_RIGHT);

        // Random sessions: mostly typing and well-formed CSI, some noise
        while (keys_sent < KEYS_TOTAL) begin
            if ($urandom_range(0, 9) == 0)
                calm <= ~calm;
            r = $urandom_range(0, 99);
            if (r < 40) begin
                repeat ($urandom_range(1, 12))
                    send_key(8'($urandom_range(lle_pkg::KEY_SPACE, lle_pkg::KEY_TILDE)));
            end else if (r < 55) begin
                case ($urandom_range(0, 7))
                    0, 1, 2: send_key(lle_pkg::KEY_DEL);
                    3, 4:    send_key(lle_pkg::KEY_HOME);
                    5, 6:    send_key(lle_pkg::KEY_END);
                    default: send_key(lle_pkg::KEY_KILL);
                endcase
            end else if (r < 80) begin
                send_key(lle_pkg::KEY_ESC);
                send_key(lle_pkg::KEY_LBRK);
                if ($urandom_range(0, 3) == 0)
                    send_key(lle_pkg::KEY_QUEST);
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(13, 17))
                        send_key(lle_pkg::KEY_SEMI);
                end else begin
                    n = $urandom_range(0, 4);
                    repeat (n)
                        send_key($urandom_range(0, 2) == 0 ? lle_pkg::KEY_SEMI
                                 : 8'($urandom_range(lle_pkg::KEY_ZERO, lle_pkg::KEY_NINE)));
                end
                case ($urandom_range(0, 8))
                    0:       send_key(lle_pkg::KEY_UP);
                    1:       send_key(lle_pkg::KEY_DOWN);
                    2, 3:    send_key(lle_pkg::KEY_RIGHT);
                    4, 5:    send_key(lle_pkg::KEY_LEFT);
                    6:       send_key(lle_pkg::KEY_TILDE);
                    7:       send_key(8'($urandom_range(0, 255)));
                    default: send_key(lle_pkg::KEY_CR);
                endcase
            end else if (r < 90) begin
                send_key($urandom_range(0, 1) ? lle_pkg::KEY_CR : lle_pkg::KEY_LF);
            end else begin
                if ($urandom_range(0, 1))
                    send_key(lle_pkg::KEY_ESC);
                send_key(8'($urandom_range(0, 255)));
            end
        end
        i_valid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lle_pkg.sv
rtl/lle_front.sv
rtl/lle_queue.sv
rtl/lle_back.sv
rtl/ansi_line_editor.sv
rtl/lle_checker.sv
verif/ansi_line_editor_tb.sv
